>>> hw/rtl/bspline_free_form_warp_core_macros.svh
// assertion macros for the warp core checker
`ifndef BSPLINE_FREE_FORM_WARP_CORE_MACROS_SVH
`define BSPLINE_FREE_FORM_WARP_CORE_MACROS_SVH

`define BFW_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`define BFW_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/bfw_pkg.sv
package bfw_pkg;
  localparam int GRID_SIZE = 16;
  localparam int COORD_WIDTH = 24;
  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam int ADDR_W = IDX_W * 2 + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  typedef struct packed {
    logic opcode;
    logic bank;
    logic [3:0] lattice_row;
    logic [3:0] lattice_col;
    logic signed [COORD_WIDTH-1:0] entry_x;
    logic signed [COORD_WIDTH-1:0] entry_y;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] warped_x;
    logic signed [COORD_WIDTH-1:0] warped_y;
    logic signed [COORD_WIDTH-1:0] warped_z;
    logic inside_lattice;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [15:0] u;
  } wgt_req_t;

  typedef struct packed {
    logic done;
    logic [4*17-1:0] w;
  } wgt_rsp_t;
endpackage

>>> hw/rtl/bfw_weights.sv
module bfw_weights (
  input  logic clk,
  input  logic rst_n,
  input  bfw_pkg::wgt_req_t req,
  output bfw_pkg::wgt_rsp_t rsp
);
  import bfw_pkg::*;

  // sequential: products through one 17x51 multiplier, then per-weight /6 by reciprocal
  typedef enum logic [3:0] {
    W_IDLE, W_U2, W_U3, W_T2, W_T3, W_NUM, W_DIV, W_DONE
  } wstate_t;

  wstate_t st_r;
  logic [16:0] u_r, t_r;
  logic [50:0] u2_r, u3_r, t2_r, t3_r;
  logic [50:0] num_r [4];
  logic [1:0] k_r;
  logic [16:0] w_r [4];
  logic [50:0] mul_a;
  logic [16:0] mul_b;
  logic [67:0] prod;
  logic [50:0] half, numk, q;

  localparam logic [50:0] FULL = 51'd1 << 48;

  assign half = 51'd3 << 32;
  assign prod = {17'd0, mul_a} * {51'd0, mul_b};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      W_U2: begin mul_a = {34'd0, u_r}; mul_b = u_r; end
      W_U3: begin mul_a = u2_r; mul_b = u_r; end
      W_T2: begin mul_a = {34'd0, t_r}; mul_b = t_r; end
      W_T3: begin mul_a = t2_r; mul_b = t_r; end
      default: ;
    endcase
  end

  // numerator plus half, divided by 6<<32: shift 33 then divide by 3
  always_comb begin
    numk = num_r[k_r] + half;
    q = numk >> 33;
  end

  // exact divide by 3 for quotients below 2^18
  logic [17:0] q18;
  logic [35:0] qm;
  logic [16:0] qd;
  always_comb begin
    q18 = q[17:0];
    qm = {18'd0, q18} * 36'd174763;
    qd = qm[35:19];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= W_IDLE;
      k_r <= '0;
    end else begin
      unique case (st_r)
        W_IDLE: if (req.start) begin
          u_r <= {1'b0, req.u};
          t_r <= 17'h10000 - {1'b0, req.u};
          st_r <= W_U2;
        end
        W_U2: begin u2_r <= prod[50:0]; st_r <= W_U3; end
        W_U3: begin u3_r <= prod[50:0]; st_r <= W_T2; end
        W_T2: begin t2_r <= prod[50:0]; st_r <= W_T3; end
        W_T3: begin t3_r <= prod[50:0]; st_r <= W_NUM; end
        W_NUM: begin
          num_r[0] <= t3_r;
          num_r[1] <= 51'd3 * u3_r + 51'd4 * FULL - 51'd6 * (u2_r << 16);
          num_r[2] <= 51'd3 * (u2_r << 16) + 51'd3 * ({34'd0, u_r} << 32) + FULL
                      - 51'd3 * u3_r;
          num_r[3] <= u3_r;
          k_r <= '0;
          st_r <= W_DIV;
        end
        W_DIV: begin
          w_r[k_r] <= qd;
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) st_r <= W_DONE;
        end
        W_DONE: st_r <= W_IDLE;
        default: st_r <= W_IDLE;
      endcase
    end
  end

  assign rsp.done = (st_r == W_DONE);
  assign rsp.w = {w_r[3], w_r[2], w_r[1], w_r[0]};

  logic unused;
  assign unused = ^{numk[32:0], q[50:18], qm[18:0]};
endmodule

>>> hw/rtl/bspline_free_form_warp_core.sv
// Cubic B-spline free-form warp over a two-bank 16x16 control lattice. A write word
// stores one control point and gives no result. A transform word runs two index
// multiplies, two weight sequences through a shared multiplier, then 16 reads from
// the lattice store, one multiply-accumulate per cycle per axis, one last accumulate,
// rounding and the load of the output register. Points outside skip to the output
// register after their index multiply. in_ready is low while a transform is in
// progress; a finished result waits in the output register without blocking the
// input, and the next result holds until it is taken.
module bspline_free_form_warp_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  bfw_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output bfw_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [bfw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bfw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOCX, S_LOCY, S_WU, S_WV, S_MAC, S_LAST, S_ROUND, S_OUT
  } state_t;

  state_t st_r;
  in_word_t w_r;
  logic signed [COORD_WIDTH-1:0] xo_r, yo_r;
  logic [15:0] xs_r, ys_r;
  logic [IDX_W-1:0] cx_r, cy_r;
  logic [15:0] fu_r, fv_r;
  logic [16:0] wu_r [4];
  logic [16:0] wv_r [4];
  logic [4:0] n_r;
  logic signed [COORD_WIDTH-1:0] mx [2**ADDR_W];
  logic signed [COORD_WIDTH-1:0] my [2**ADDR_W];
  logic signed [COORD_WIDTH-1:0] rdx_r, rdy_r;
  logic [16:0] w2_r;
  logic signed [COORD_WIDTH+18:0] ax_r, ay_r;
  out_word_t res_r;
  out_word_t o_r;
  logic ov_r;

  // index multiply, shared for x and y
  logic signed [COORD_WIDTH:0] diff;
  logic signed [COORD_WIDTH+17:0] idx;
  logic loc_ok;
  logic [COORD_WIDTH+17-24:0] ip;
  always_comb begin
    if (st_r == S_LOCX) diff = {w_r.point_x[COORD_WIDTH-1], w_r.point_x}
                               - {xo_r[COORD_WIDTH-1], xo_r};
    else diff = {w_r.point_y[COORD_WIDTH-1], w_r.point_y} - {yo_r[COORD_WIDTH-1], yo_r};
    idx = diff * $signed({1'b0, (st_r == S_LOCX) ? xs_r : ys_r});
    ip = idx[COORD_WIDTH+17:24];
    loc_ok = !idx[COORD_WIDTH+17] && ip >= 1 && ip <= GRID_SIZE - 3;
  end

  wgt_req_t wreq;
  wgt_rsp_t wrsp;
  logic wstart_r;
  assign wreq.start = wstart_r;
  assign wreq.u = (st_r == S_WU) ? fu_r : fv_r;
  bfw_weights u_wgt (.clk(clk), .rst_n(rst_n), .req(wreq), .rsp(wrsp));

  // mac step n: m = n[3:2] (x), k = n[1:0] (y)
  logic [1:0] mi, ni;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [33:0] wp;
  assign mi = n_r[3:2];
  assign ni = n_r[1:0];
  assign raddr = {w_r.bank, cy_r + IDX_W'(ni), cx_r + IDX_W'(mi)};
  assign waddr = {in_data.bank, in_data.lattice_row[IDX_W-1:0],
                  in_data.lattice_col[IDX_W-1:0]};
  assign wp = {17'd0, wu_r[mi]} * {17'd0, wv_r[ni]} + 34'd32768;

  logic signed [COORD_WIDTH+18:0] px, py, rx, ry;
  assign px = $signed({1'b0, w2_r}) * rdx_r;
  assign py = $signed({1'b0, w2_r}) * rdy_r;
  assign rx = (ax_r + 43'sd32768) >>> 16;
  assign ry = (ay_r + 43'sd32768) >>> 16;

  localparam logic signed [COORD_WIDTH+18:0] HI = (43'sd1 <<< (COORD_WIDTH-1)) - 43'sd1;
  localparam logic signed [COORD_WIDTH+18:0] LO = -HI - 43'sd1;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.opcode == OP_WRITE) begin
      mx[waddr] <= in_data.entry_x;
      my[waddr] <= in_data.entry_y;
    end
    rdx_r <= mx[raddr];
    rdy_r <= my[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      wstart_r <= 1'b0;
      xo_r <= '0;
      yo_r <= '0;
      xs_r <= 16'd4096;
      ys_r <= 16'd4096;
    end else begin
      wstart_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_X_ORIGIN: xo_r <= cfg_wdata;
          REG_Y_ORIGIN: yo_r <= cfg_wdata;
          REG_X_SCALE: xs_r <= cfg_wdata[15:0];
          REG_Y_SCALE: ys_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid && in_data.opcode == OP_TRANSFORM) begin
          w_r <= in_data;
          st_r <= S_LOCX;
        end
        S_LOCX: begin
          cx_r <= IDX_W'(ip - 1);
          fu_r <= idx[23:8];
          st_r <= loc_ok ? S_LOCY : S_OUT;
          res_r <= {w_r.point_x, w_r.point_y, w_r.point_z, 1'b0};
        end
        S_LOCY: begin
          cy_r <= IDX_W'(ip - 1);
          fv_r <= idx[23:8];
          if (loc_ok) begin
            st_r <= S_WU;
            wstart_r <= 1'b1;
          end else st_r <= S_OUT;
        end
        S_WU: if (wrsp.done) begin
          for (int i = 0; i < 4; i++) wu_r[i] <= wrsp.w[i*17 +: 17];
          st_r <= S_WV;
          wstart_r <= 1'b1;
        end
        S_WV: if (wrsp.done) begin
          for (int i = 0; i < 4; i++) wv_r[i] <= wrsp.w[i*17 +: 17];
          st_r <= S_MAC;
          n_r <= '0;
          ax_r <= '0;
          ay_r <= '0;
        end
        S_MAC: begin
          // read and weight issued for n, accumulate for n-1
          w2_r <= wp[32:16];
          if (n_r != 5'd0) begin
            ax_r <= ax_r + px;
            ay_r <= ay_r + py;
          end
          n_r <= n_r + 5'd1;
          if (n_r == 5'd15) st_r <= S_LAST;
        end
        S_LAST: begin
          ax_r <= ax_r + px;
          ay_r <= ay_r + py;
          st_r <= S_ROUND;
        end
        S_ROUND: begin
          res_r.warped_x <= (rx > HI) ? HI[COORD_WIDTH-1:0] :
                            (rx < LO) ? LO[COORD_WIDTH-1:0] : rx[COORD_WIDTH-1:0];
          res_r.warped_y <= (ry > HI) ? HI[COORD_WIDTH-1:0] :
                            (ry < LO) ? LO[COORD_WIDTH-1:0] : ry[COORD_WIDTH-1:0];
          res_r.inside_lattice <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: if (!ov_r) begin
          o_r <= res_r;
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data = o_r;

  logic unused;
  assign unused = ^{wp[33], wp[15:0], idx[7:0]};
endmodule

>>> hw/rtl/bfw_checker.sv
`include "bspline_free_form_warp_core_macros.svh"

module bfw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input bfw_pkg::in_word_t in_data,
  input bfw_pkg::out_word_t out_data
);
  import bfw_pkg::*;

  `BFW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `BFW_ASSERT_NXT(a_write_no_result, clk, rst_n,
    in_valid && in_ready && in_data.opcode == OP_WRITE && !out_valid, !out_valid)
  `BFW_ASSERT_NXT(a_write_one_cycle, clk, rst_n,
    in_valid && in_ready && in_data.opcode == OP_WRITE, in_ready)
  `BFW_ASSERT_NXT(a_transform_busy, clk, rst_n,
    in_valid && in_ready && in_data.opcode == OP_TRANSFORM, !in_ready)
endmodule

bind bspline_free_form_warp_core bfw_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .in_data(in_data), .out_data(out_data)
);

>>> test/bspline_free_form_warp_core_checker.sv
`timescale 1ns / 100ps

module bspline_free_form_warp_core_checker
  import bfw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_word_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_word_t out_data,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int fail_count,
  output int pending,
  output int inside_seen,
  output int outside_seen
);

  logic signed [COORD_WIDTH-1:0] lat_x [2*GRID_SIZE*GRID_SIZE];
  logic signed [COORD_WIDTH-1:0] lat_y [2*GRID_SIZE*GRID_SIZE];
  logic signed [COORD_WIDTH-1:0] x_org, y_org;
  logic [15:0] x_scl, y_scl;
  out_word_t warp_q[$];

  assign pending = warp_q.size();

  function automatic logic [3:0][31:0] spline_weights(input logic [15:0] u);
    bit [63:0] uu, u2, u3, t, t3, full, half, dv;
    logic [3:0][31:0] w;
    uu = u;
    u2 = uu * uu;
    u3 = u2 * uu;
    t = 64'd65536 - uu;
    t3 = t * t * t;
    full = 64'd1 << 48;
    half = 64'd3 << 32;
    dv = 64'd6 << 32;
    w[0] = 32'((t3 + half) / dv);
    w[1] = 32'((3 * u3 + 4 * full - 6 * (u2 << 16) + half) / dv);
    w[2] = 32'((3 * (u2 << 16) + 3 * (uu << 32) + full - 3 * u3 + half) / dv);
    w[3] = 32'((u3 + half) / dv);
    return w;
  endfunction

  function automatic bit locate(input logic signed [COORD_WIDTH-1:0] p, org,
                                input logic [15:0] scl, output int corner,
                                output logic [15:0] frac);
    longint prod, ip;
    prod = (longint'(p) - longint'(org)) * longint'({1'b0, scl});
    corner = 0;
    frac = '0;
    if (prod < 0) return 0;
    ip = prod >>> 24;
    if (ip < 1 || ip - 1 > GRID_SIZE - 4) return 0;
    corner = int'(ip - 1);
    frac = prod[23:8];
    return 1;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] round_sat(input longint acc);
    longint v;
    v = (acc + 32768) >>> 16;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic out_word_t warp_point(input in_word_t w);
    out_word_t r;
    int ci, cj;
    logic [15:0] fu, fv;
    logic [3:0][31:0] wu, wv;
    longint ax, ay, wt;
    int a;
    r.warped_x = w.point_x;
    r.warped_y = w.point_y;
    r.warped_z = w.point_z;
    r.inside_lattice = 1'b0;
    if (locate(w.point_x, x_org, x_scl, ci, fu) && locate(w.point_y, y_org, y_scl, cj, fv)) begin
      wu = spline_weights(fu);
      wv = spline_weights(fv);
      ax = 0;
      ay = 0;
      for (int m = 0; m < 4; m++) begin
        for (int n = 0; n < 4; n++) begin
          wt = (longint'(wu[m]) * longint'(wv[n]) + 32768) >>> 16;
          a = int'(w.bank) * GRID_SIZE * GRID_SIZE + (cj + n) * GRID_SIZE + ci + m;
          ax += wt * longint'(lat_x[a]);
          ay += wt * longint'(lat_y[a]);
        end
      end
      r.warped_x = round_sat(ax);
      r.warped_y = round_sat(ay);
      r.inside_lattice = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      x_org <= '0;
      y_org <= '0;
      x_scl <= 16'd4096;
      y_scl <= 16'd4096;
      warp_q.delete();
      fail_count <= 0;
      inside_seen <= 0;
      outside_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (warp_q.size() == 0) begin
          $display("%0t: result word with none expected: %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = warp_q.pop_front();
          if (e.warped_x !== out_data.warped_x || e.warped_y !== out_data.warped_y ||
              e.warped_z !== out_data.warped_z ||
              e.inside_lattice !== out_data.inside_lattice) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d in=%0b got x=%0d y=%0d z=%0d in=%0b",
                     $time, e.warped_x, e.warped_y, e.warped_z, e.inside_lattice,
                     out_data.warped_x, out_data.warped_y, out_data.warped_z,
                     out_data.inside_lattice);
            fail_count <= fail_count + 1;
          end
          if (e.inside_lattice) inside_seen <= inside_seen + 1;
          else outside_seen <= outside_seen + 1;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == OP_WRITE) begin
          lat_x[{in_data.bank, in_data.lattice_row, in_data.lattice_col}] = in_data.entry_x;
          lat_y[{in_data.bank, in_data.lattice_row, in_data.lattice_col}] = in_data.entry_y;
        end else begin
          warp_q.insert(warp_q.size(), warp_point(in_data));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_X_ORIGIN: x_org <= cfg_wdata;
          REG_Y_ORIGIN: y_org <= cfg_wdata;
          REG_X_SCALE:  x_scl <= cfg_wdata[15:0];
          REG_Y_SCALE:  y_scl <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> test/tb_bspline_free_form_warp_core.sv
`timescale 1ns / 100ps

module tb_bspline_free_form_warp_core;
  import bfw_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 60;
  localparam int PER_PHASE = 180;
  localparam int IN_W = $bits(in_word_t);

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fail_count, pending, inside_seen, outside_seen;
  int gap_pct, stall_pct, words_sent, quiet_cycles;
  logic signed [COORD_WIDTH-1:0] x_org, y_org;
  logic [15:0] x_scl, y_scl;

  bspline_free_form_warp_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bspline_free_form_warp_core_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending),
    .inside_seen(inside_seen), .outside_seen(outside_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("** bspline_free_form_warp_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send(input in_word_t w);
    bit acc;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic set_lattice_map(input int xo, input int yo, input int xs, input int ys);
    drain();
    x_org = COORD_WIDTH'(xo);
    y_org = COORD_WIDTH'(yo);
    x_scl = 16'(xs);
    y_scl = 16'(ys);
    write_reg(REG_X_ORIGIN, x_org);
    write_reg(REG_Y_ORIGIN, y_org);
    write_reg(REG_X_SCALE, {8'($urandom), x_scl});
    write_reg(REG_Y_SCALE, {8'($urandom), y_scl});
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_word_t lattice_write(input bit bank, input int row, input int col);
    in_word_t w;
    w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    w.opcode = OP_WRITE;
    w.bank = bank;
    w.lattice_row = 4'(row);
    w.lattice_col = 4'(col);
    w.entry_x = rand_coord();
    w.entry_y = rand_coord();
    return w;
  endfunction

  // mostly lands near the lattice, spanning a little past both ends
  function automatic logic signed [COORD_WIDTH-1:0] aim(input logic signed [COORD_WIDTH-1:0] org,
                                                       input logic [15:0] scl);
    longint span;
    if (scl == 0 || $urandom_range(9) < 2) return rand_coord();
    span = (longint'(17) << 24) / scl;
    if (span > 24'hffffff) span = 24'hffffff;
    return 24'(longint'(org) + longint'($urandom_range(int'(span))) - 64);
  endfunction

  function automatic in_word_t transform(input bit bank, input logic signed [COORD_WIDTH-1:0] px,
                                         input logic signed [COORD_WIDTH-1:0] py,
                                         input logic signed [COORD_WIDTH-1:0] pz);
    in_word_t w;
    w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    w.opcode = OP_TRANSFORM;
    w.bank = bank;
    w.point_x = px;
    w.point_y = py;
    w.point_z = pz;
    return w;
  endfunction

  task automatic random_words(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15)
        send(lattice_write(1'($urandom_range(1)), $urandom_range(15), $urandom_range(15)));
      else
        send(transform(1'($urandom_range(1)), aim(x_org, x_scl), aim(y_org, y_scl),
                       rand_coord()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    gap_pct = 10;
    stall_pct = 46;
    words_sent = 0;
    quiet_cycles = 0;
    x_org = 0;
    y_org = 0;
    x_scl = 16'd4096;
    y_scl = 16'd4096;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both banks so no transform reads an unwritten entry
    for (int b = 0; b < 2; b++)
      for (int r = 0; r < GRID_SIZE; r++)
        for (int c = 0; c < GRID_SIZE; c++)
          send(lattice_write(1'(b), r, c));

    // directed: lattice edges at reset mapping, extremes of every field
    send(transform(0, 24'sd4096, 24'sd4096, 24'h800000));
    send(transform(1, 24'sd57343, 24'sd57343, 24'h7fffff));
    send(transform(0, 24'sd57344, 24'sd8192, 24'sd0));
    send(transform(1, 24'sd8192, 24'sd57344, -24'sd1));
    send(transform(0, 24'sd4095, 24'sd20000, 24'sd1));
    send(transform(1, -24'sd1, 24'sd20000, 24'sd5));
    send(transform(0, 24'h800000, 24'h7fffff, 24'sd9));
    send(transform(1, 24'h7fffff, 24'h800000, 24'sd9));
    send(transform(0, 24'sd0, 24'sd0, 24'sd0));
    for (int k = 0; k < 4; k++) begin
      in_word_t w;
      w = lattice_write(k[0], 4 + k, 4 + k);
      w.entry_x = k[1] ? 24'h7fffff : 24'h800000;
      w.entry_y = k[1] ? 24'h800000 : 24'h7fffff;
      send(w);
    end
    send(lattice_write(1, 15, 15));
    send(lattice_write(0, 0, 0));
    send(transform(0, 24'sd20480, 24'sd20480, 24'sd3));
    send(transform(1, 24'sd24000, 24'sd24000, 24'sd3));
    send(transform(0, 24'sd12288, 24'sd12288, 24'sd3));

    gap_pct = 10;
    stall_pct = 46;
    set_lattice_map(0, 0, 4096, 4096);
    random_words(PER_PHASE);
    set_lattice_map(-8388608, 8388607, 65535, 65535);
    random_words(PER_PHASE / 2);
    gap_pct = 46;
    stall_pct = 10;
    random_words(PER_PHASE / 2);
    set_lattice_map(12345, -54321, 20000, 9000);
    random_words(PER_PHASE / 2);
    // hold off until the block has delivered everything
    drain();
    random_words(PER_PHASE / 2);
    gap_pct = 0;
    stall_pct = 0;
    set_lattice_map(8388607, -8388608, 0, 1);
    random_words(PER_PHASE / 2);
    set_lattice_map(-256, 256, 65535, 4096);
    random_words(PER_PHASE);

    drain();
    $display("sent %0d words over five lattice mappings and three idle patterns", words_sent);
    $display("checked %0d deformed and %0d passed-through points", inside_seen, outside_seen);
    if (fail_count == 0) begin
      $display("** bspline_free_form_warp_core: PASSED **");
    end else begin
      $display("** bspline_free_form_warp_core: FAILED **");
    end
    $finish;
  end

endmodule
